// ----- hdl/pdist_pkg.sv -----
`default_nettype none
package pdist_pkg;

  // default sizes handed to the top level
  localparam int MAX_POINTS_DEF  = 32;
  localparam int COORD_WIDTH_DEF = 16;

  // fixed field widths
  localparam int IDX_W      = 5;
  localparam int CFG_W      = 6;
  localparam int DIST_W     = 17;
  localparam int OUT_DATA_W = ((DIST_W + IDX_W + 7) / 8) * 8;

  // square root datapath: 34-bit radicand, one result bit per cell
  localparam int RAD_W  = 2 * DIST_W;
  localparam int REM_W  = DIST_W + 2;
  localparam int ROOT_W = DIST_W;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(32);

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_ISSUE
  } state_t;

  // item bookkeeping that travels alongside the datapath
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [IDX_W-1:0] idx;
  } tag_t;

  typedef struct packed {
    tag_t              tag;
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_tok_t;

endpackage
`default_nettype wire

// ----- hdl/pdist_point_mem.sv -----
`default_nettype none
module pdist_point_mem #(
  parameter int MAX_POINTS  = pdist_pkg::MAX_POINTS_DEF,
  parameter int COORD_WIDTH = pdist_pkg::COORD_WIDTH_DEF
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    en,
  input  wire                                    wr_en,
  input  wire [((MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1)-1:0] wr_addr,
  input  wire signed [COORD_WIDTH-1:0]           wr_x,
  input  wire signed [COORD_WIDTH-1:0]           wr_y,
  input  wire pdist_pkg::tag_t                   rd_tag,
  input  wire [((MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1)-1:0] rd_addr,
  input  wire signed [COORD_WIDTH-1:0]           probe_x,
  input  wire signed [COORD_WIDTH-1:0]           probe_y,
  output pdist_pkg::tag_t                        fetch_tag,
  output logic signed [COORD_WIDTH-1:0]          fetch_px,
  output logic signed [COORD_WIDTH-1:0]          fetch_py,
  output logic signed [COORD_WIDTH-1:0]          fetch_sx,
  output logic signed [COORD_WIDTH-1:0]          fetch_sy
);

  logic [2*COORD_WIDTH-1:0] mem [MAX_POINTS];
  pdist_pkg::tag_t          tag_r;
  logic [2*COORD_WIDTH-1:0] rd_data_r;
  logic signed [COORD_WIDTH-1:0] px_r, py_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_y, wr_x};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_data_r <= mem[rd_addr];
      px_r      <= probe_x;
      py_r      <= probe_y;
      tag_r.last <= rd_tag.last;
      tag_r.idx  <= rd_tag.idx;
    end
    if (!rst_n) begin
      tag_r.valid <= 1'b0;
    end else if (en) begin
      tag_r.valid <= rd_tag.valid;
    end
  end

  assign fetch_tag = tag_r;
  assign fetch_px  = px_r;
  assign fetch_py  = py_r;
  assign fetch_sx  = rd_data_r[COORD_WIDTH-1:0];
  assign fetch_sy  = rd_data_r[2*COORD_WIDTH-1:COORD_WIDTH];

endmodule
`default_nettype wire

// ----- hdl/pdist_dist_front.sv -----
`default_nettype none
module pdist_dist_front #(
  parameter int COORD_WIDTH = pdist_pkg::COORD_WIDTH_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           en,
  input  wire pdist_pkg::tag_t          tag_in,
  input  wire signed [COORD_WIDTH-1:0]  px,
  input  wire signed [COORD_WIDTH-1:0]  py,
  input  wire signed [COORD_WIDTH-1:0]  sx,
  input  wire signed [COORD_WIDTH-1:0]  sy,
  output pdist_pkg::sqrt_tok_t          tok_out
);

  localparam int CW    = COORD_WIDTH;
  localparam int PW    = 2 * CW;
  localparam int SW    = 2 * CW + 1;
  localparam int RAD_W = pdist_pkg::RAD_W;

  // stage 1: absolute differences
  logic signed [CW:0] diff_x, diff_y;
  logic [CW-1:0]      dx_abs, dy_abs;
  logic               sat1;
  logic [CW-1:0]      dx_r, dy_r;
  logic               sat1_r;
  pdist_pkg::tag_t    tag1_r;

  // stage 2: squares
  logic [PW-1:0]      sqx_r, sqy_r;
  logic               sat2_r;
  pdist_pkg::tag_t    tag2_r;

  // stage 3: sum and saturation
  logic [SW-1:0]      sum;
  logic               sat3;
  logic [RAD_W-1:0]   rad_r;
  pdist_pkg::tag_t    tag3_r;

  always_comb begin
    diff_x = {px[CW-1], px} - {sx[CW-1], sx};
    diff_y = {py[CW-1], py} - {sy[CW-1], sy};
    dx_abs = diff_x[CW] ? CW'(-diff_x) : diff_x[CW-1:0];
    dy_abs = diff_y[CW] ? CW'(-diff_y) : diff_y[CW-1:0];
    // a difference of 2^17 or more is out of distance range already
    sat1   = ((64'(dx_abs) >> pdist_pkg::DIST_W) != 64'd0) ||
             ((64'(dy_abs) >> pdist_pkg::DIST_W) != 64'd0);
    sum    = SW'(sqx_r) + SW'(sqy_r);
    sat3   = sat2_r || ((64'(sum) >> RAD_W) != 64'd0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r   <= dx_abs;
      dy_r   <= dy_abs;
      sat1_r <= sat1;
      sqx_r  <= PW'(dx_r) * PW'(dx_r);
      sqy_r  <= PW'(dy_r) * PW'(dy_r);
      sat2_r <= sat1_r;
      // all ones gives a root of exactly 2^17 - 1
      rad_r  <= sat3 ? {RAD_W{1'b1}} : RAD_W'(sum);
      tag1_r.last <= tag_in.last;
      tag1_r.idx  <= tag_in.idx;
      tag2_r.last <= tag1_r.last;
      tag2_r.idx  <= tag1_r.idx;
      tag3_r.last <= tag2_r.last;
      tag3_r.idx  <= tag2_r.idx;
    end
    if (!rst_n) begin
      tag1_r.valid <= 1'b0;
      tag2_r.valid <= 1'b0;
      tag3_r.valid <= 1'b0;
    end else if (en) begin
      tag1_r.valid <= tag_in.valid;
      tag2_r.valid <= tag1_r.valid;
      tag3_r.valid <= tag2_r.valid;
    end
  end

  always_comb begin
    tok_out.tag  = tag3_r;
    tok_out.rad  = rad_r;
    tok_out.rem  = '0;
    tok_out.root = '0;
  end

endmodule
`default_nettype wire

// ----- hdl/pdist_sqrt_cell.sv -----
`default_nettype none
module pdist_sqrt_cell (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       en,
  input  wire pdist_pkg::sqrt_tok_t tok_in,
  output pdist_pkg::sqrt_tok_t      tok_out
);

  localparam int RAD_W  = pdist_pkg::RAD_W;
  localparam int REM_W  = pdist_pkg::REM_W;
  localparam int ROOT_W = pdist_pkg::ROOT_W;
  localparam int WR     = REM_W + 2;

  pdist_pkg::sqrt_tok_t tok_r, tok_nxt;
  logic [WR-1:0]        rem_sh, trial;

  // one result bit: bring down two radicand bits, try root*4+1
  always_comb begin
    rem_sh  = {tok_in.rem, tok_in.rad[RAD_W-1:RAD_W-2]};
    trial   = WR'({tok_in.root, 2'b01});
    tok_nxt = tok_in;
    tok_nxt.rad = {tok_in.rad[RAD_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      tok_nxt.rem  = REM_W'(rem_sh - trial);
      tok_nxt.root = {tok_in.root[ROOT_W-2:0], 1'b1};
    end else begin
      tok_nxt.rem  = REM_W'(rem_sh);
      tok_nxt.root = {tok_in.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tok_r.rad      <= tok_nxt.rad;
      tok_r.rem      <= tok_nxt.rem;
      tok_r.root     <= tok_nxt.root;
      tok_r.tag.last <= tok_nxt.tag.last;
      tok_r.tag.idx  <= tok_nxt.tag.idx;
    end
    if (!rst_n) begin
      tok_r.tag.valid <= 1'b0;
    end else if (en) begin
      tok_r.tag.valid <= tok_nxt.tag.valid;
    end
  end

  assign tok_out = tok_r;

endmodule
`default_nettype wire

// ----- hdl/pairwise_distance_engine.sv -----
`default_nettype none
// pairwise distance engine: keeps up to MAX_POINTS reference points with signed
// COORD_WIDTH-bit x/y coordinates and, per query, emits the floor of the euclidean
// distance from the probe to stored points 0 .. points_in_use-1, one column of the
// distance matrix, with tlast on the final result. tuser = 0 loads the point in
// tdata into slot point_index (slots at or beyond MAX_POINTS are dropped, no
// result). tuser = 1 is a query: the sequencer reads one stored point per cycle
// from the point memory while the output is not stalled and takes no new input
// while it walks the store, and results stream out at one per cycle once the pipe
// is full and the output is not stalled. a point read passes through the memory
// read, three front-end stages (difference, squares, sum), a row of 17 square root
// cells that each settle one result bit, and the output register. a stalled output
// freezes the whole pipe. points_in_use resets to 32, is clamped to MAX_POINTS, and
// zero makes a query produce nothing. distances beyond 17 bits (wide coordinates
// only) saturate to all ones. slots hold garbage until loaded, and a query must not
// reach an unloaded slot; there is no clearing pass after reset.
module pairwise_distance_engine #(
  parameter int MAX_POINTS  = pdist_pkg::MAX_POINTS_DEF,
  parameter int COORD_WIDTH = pdist_pkg::COORD_WIDTH_DEF
) (
  input  wire                                         clk,
  input  wire                                         rst_n,
  // input channel
  input  wire                                         in_tvalid,
  output logic                                        in_tready,
  // point_index [4:0], coord_x, coord_y, zero padding
  input  wire [((pdist_pkg::IDX_W + 2*COORD_WIDTH + 7) / 8) * 8 - 1:0] in_tdata,
  // op (0 load, 1 query)
  input  wire                                         in_tuser,
  // result channel
  output logic                                        out_tvalid,
  input  wire                                         out_tready,
  // distance [16:0], ref_index [21:17], zero padding
  output logic [pdist_pkg::OUT_DATA_W-1:0]            out_tdata,
  output logic                                        out_tlast,
  // configuration: points_in_use
  input  wire                                         cfg_valid,
  output logic                                        cfg_ready,
  input  wire [pdist_pkg::CFG_W-1:0]                  cfg_data
);

  localparam int CW     = COORD_WIDTH;
  localparam int AW     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int IDX_W  = pdist_pkg::IDX_W;
  localparam int DIST_W = pdist_pkg::DIST_W;
  localparam int NCELLS = pdist_pkg::ROOT_W;

  // input field unpacking
  logic [IDX_W-1:0]     in_point_index;
  logic signed [CW-1:0] in_coord_x, in_coord_y;
  logic                 in_fire, load_fire, query_fire;
  logic                 slot_ok;

  // configuration register
  logic [pdist_pkg::CFG_W-1:0] cfg_r;
  logic [CNT_W-1:0]            count_sat;

  // query sequencer
  pdist_pkg::state_t    state_r, state_nxt;
  logic [AW-1:0]        k_r, k_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic signed [CW-1:0] probe_x_r, probe_y_r;
  pdist_pkg::tag_t      rd_tag;

  // pipe enable: everything moves unless a result sits unclaimed
  logic                 en;

  // datapath links
  pdist_pkg::tag_t      fetch_tag;
  logic signed [CW-1:0] fetch_px, fetch_py, fetch_sx, fetch_sy;
  pdist_pkg::sqrt_tok_t chain [NCELLS+1];

  // output register
  logic                 out_valid_r;
  logic [DIST_W-1:0]    out_dist_r;
  logic [IDX_W-1:0]     out_idx_r;
  logic                 out_last_r;

  assign in_point_index = in_tdata[IDX_W-1:0];
  assign in_coord_x     = in_tdata[IDX_W+CW-1:IDX_W];
  assign in_coord_y     = in_tdata[IDX_W+2*CW-1:IDX_W+CW];

  assign in_fire    = in_tvalid && in_tready;
  assign load_fire  = in_fire && (in_tuser == pdist_pkg::OP_LOAD);
  assign query_fire = in_fire && (in_tuser == pdist_pkg::OP_QUERY);
  assign slot_ok    = (32'(in_point_index) < 32'(MAX_POINTS));

  assign en = !out_valid_r || out_tready;

  // config port never stalls
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= pdist_pkg::CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cfg_r <= cfg_data;
    end
  end

  // clamp the count to the store depth
  assign count_sat = (32'(cfg_r) > 32'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : CNT_W'(cfg_r);

  // sequencer: idle takes loads and queries, issue walks the store one slot per cycle unless stalled
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    count_nxt = count_r;
    in_tready = 1'b0;
    rd_tag.valid = 1'b0;
    rd_tag.last  = (CNT_W'(k_r) + CNT_W'(1)) == count_r;
    rd_tag.idx   = IDX_W'(k_r);
    unique case (state_r)
      pdist_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (query_fire) begin
          k_nxt     = '0;
          count_nxt = count_sat;
          if (count_sat != '0) begin
            state_nxt = pdist_pkg::ST_ISSUE;
          end
        end
      end
      pdist_pkg::ST_ISSUE: begin
        if (en) begin
          rd_tag.valid = 1'b1;
          k_nxt        = AW'(k_r + AW'(1));
          if (rd_tag.last) begin
            state_nxt = pdist_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = pdist_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pdist_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r     <= k_nxt;
    count_r <= count_nxt;
    if (query_fire) begin
      probe_x_r <= in_coord_x;
      probe_y_r <= in_coord_y;
    end
  end

  // point store with registered read; probe rides along with the read
  pdist_point_mem #(
    .MAX_POINTS  (MAX_POINTS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .wr_en     (load_fire && slot_ok),
    .wr_addr   (AW'(in_point_index)),
    .wr_x      (in_coord_x),
    .wr_y      (in_coord_y),
    .rd_tag    (rd_tag),
    .rd_addr   (k_r),
    .probe_x   (probe_x_r),
    .probe_y   (probe_y_r),
    .fetch_tag (fetch_tag),
    .fetch_px  (fetch_px),
    .fetch_py  (fetch_py),
    .fetch_sx  (fetch_sx),
    .fetch_sy  (fetch_sy)
  );

  // |dx|, |dy|, squares, sum into the square root radicand
  pdist_dist_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .tag_in  (fetch_tag),
    .px      (fetch_px),
    .py      (fetch_py),
    .sx      (fetch_sx),
    .sy      (fetch_sy),
    .tok_out (chain[0])
  );

  // row of square root cells, msb of the root first
  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    pdist_sqrt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

  // output register parts the pipe from the consumer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= chain[NCELLS].tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_dist_r <= chain[NCELLS].root;
      out_idx_r  <= chain[NCELLS].tag.idx;
      out_last_r <= chain[NCELLS].tag.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = pdist_pkg::OUT_DATA_W'({out_idx_r, out_dist_r});

endmodule
`default_nettype wire

// ----- bench/pdist_column_check.sv -----
`timescale 1ns / 1ps
// watches all three channels, predicts each query's distance column and
// compares every result transaction against it
module pdist_column_check
  import pdist_pkg::*;
#(
  parameter int IN_DATA_W = ((IDX_W + 2 * COORD_WIDTH_DEF + 7) / 8) * 8
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_tvalid,
  input  wire                  in_tready,
  input  wire [IN_DATA_W-1:0]  in_tdata,
  input  wire                  in_tuser,
  input  wire                  out_tvalid,
  input  wire                  out_tready,
  input  wire [OUT_DATA_W-1:0] out_tdata,
  input  wire                  out_tlast,
  input  wire                  cfg_valid,
  input  wire                  cfg_ready,
  input  wire [CFG_W-1:0]      cfg_data,
  output int                   outstanding,
  output int                   fail_count
);

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [IDX_W-1:0]  idx;
    logic              last;
  } dist_result_t;

  logic signed [COORD_WIDTH_DEF-1:0] ref_x [MAX_POINTS_DEF];
  logic signed [COORD_WIDTH_DEF-1:0] ref_y [MAX_POINTS_DEF];
  logic [CFG_W-1:0] active_points;
  dist_result_t     column_q[$];
  int               errors = 0;

  // bitwise floor square root, one result bit per pass from the top
  function automatic logic [DIST_W-1:0] floor_root(input logic [63:0] radicand);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = DIST_W - 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= radicand) root = trial;
    end
    return root[DIST_W-1:0];
  endfunction

  function automatic logic [DIST_W-1:0] probe_distance(
    input logic signed [COORD_WIDTH_DEF-1:0] ax,
    input logic signed [COORD_WIDTH_DEF-1:0] ay,
    input logic signed [COORD_WIDTH_DEF-1:0] bx,
    input logic signed [COORD_WIDTH_DEF-1:0] by
  );
    logic signed [COORD_WIDTH_DEF+1:0] dx;
    logic signed [COORD_WIDTH_DEF+1:0] dy;
    logic [63:0] adx;
    logic [63:0] ady;
    dx  = ax - bx;
    dy  = ay - by;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    return floor_root(adx * adx + ady * ady);
  endfunction

  always @(posedge clk) begin : track
    dist_result_t seen;
    dist_result_t want;
    logic signed [COORD_WIDTH_DEF-1:0] px;
    logic signed [COORD_WIDTH_DEF-1:0] py;
    int n;
    if (!rst_n) begin
      active_points = CFG_RESET;
      column_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        seen.distance = out_tdata[DIST_W-1:0];
        seen.idx      = out_tdata[DIST_W +: IDX_W];
        seen.last     = out_tlast;
        if (column_q.size() == 0) begin
          errors++;
          $display("%0t: expected no result, got distance %0d ref_index %0d last %0b",
                   $time, seen.distance, seen.idx, seen.last);
        end else begin
          want = column_q.pop_front();
          if (seen.distance !== want.distance) begin
            errors++;
            $display("%0t: distance at ref_index %0d: expected %0d, got %0d",
                     $time, want.idx, want.distance, seen.distance);
          end
          if (seen.idx !== want.idx) begin
            errors++;
            $display("%0t: ref_index: expected %0d, got %0d", $time, want.idx, seen.idx);
          end
          if (seen.last !== want.last) begin
            errors++;
            $display("%0t: last at ref_index %0d: expected %0b, got %0b",
                     $time, want.idx, want.last, seen.last);
          end
        end
      end
      if (cfg_valid && cfg_ready) active_points = cfg_data;
      if (in_tvalid && in_tready) begin
        px = in_tdata[IDX_W +: COORD_WIDTH_DEF];
        py = in_tdata[IDX_W + COORD_WIDTH_DEF +: COORD_WIDTH_DEF];
        if (in_tuser == OP_LOAD) begin
          ref_x[in_tdata[IDX_W-1:0]] = px;
          ref_y[in_tdata[IDX_W-1:0]] = py;
        end else begin
          n = (active_points > MAX_POINTS_DEF) ? MAX_POINTS_DEF : active_points;
          for (int k = 0; k < n; k++) begin
            want.distance = probe_distance(ref_x[k], ref_y[k], px, py);
            want.idx      = IDX_W'(k);
            want.last     = (k == n - 1);
            column_q.push_back(want);
          end
        end
      end
    end
    outstanding <= column_q.size();
    fail_count  <= errors;
  end

endmodule

// ----- bench/tb_pairwise_distance_engine.sv -----
`timescale 1ns / 1ps
// drives point loads, queries and point-count writes into the distance engine;
// the column checker beside it predicts and compares every result transaction
module tb_pairwise_distance_engine;
  import pdist_pkg::*;

  localparam int IN_DATA_W   = ((IDX_W + 2 * COORD_WIDTH_DEF + 7) / 8) * 8;
  // cycles with no transaction on any channel before the run is declared hung
  localparam int STALL_LIMIT = 2000;
  // settle time after the last expected result: pipe is 22 deep
  localparam int TAIL_CYCLES = 40;
  localparam int PHASE_ITEMS = 51;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  // point_index [4:0], coord_x [20:5], coord_y [36:21], zero padding
  logic [IN_DATA_W-1:0]  in_tdata;
  // op (0 load, 1 query)
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  // distance [16:0], ref_index [21:17], zero padding
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_data;

  int outstanding;
  int fail_count;
  int quiet_cycles = 0;

  // percent of cycles in which each side holds back
  int in_gap_pct;
  int out_gap_pct;

  // which slots hold a point, so no query ever reaches an unloaded slot
  logic [MAX_POINTS_DEF-1:0] loaded_slots;
  logic [CFG_W-1:0]          points_setting;
  int                        items_sent;

  // point counts for the random phases: full store, saturating values, zero, partial counts
  logic [CFG_W-1:0] phase_setting [8] = '{6'd32, 6'd63, 6'd1, 6'd33, 6'd0, 6'd2, 6'd31, 6'd17};

  pairwise_distance_engine uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  pdist_column_check column_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side backpressure, redrawn every cycle
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= out_gap_pct);
    end
  end

  // hang detection: any transaction on any channel resets the count
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("tb_pairwise_distance_engine NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // coordinates biased toward the extremes and toward small values near zero
  function automatic logic signed [COORD_WIDTH_DEF-1:0] pick_coord();
    case ($urandom_range(7))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      3:       return -16'sd1;
      4:       return 16'($urandom_range(32) - 16);
      default: return 16'($urandom);
    endcase
  endfunction

  // one input transaction; valid stays high after the handshake so that
  // back-to-back items need no extra assignment in the same step
  task automatic send_item(input logic op, input logic [IDX_W-1:0] slot,
                           input logic signed [COORD_WIDTH_DEF-1:0] x,
                           input logic signed [COORD_WIDTH_DEF-1:0] y);
    while ($urandom_range(99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_DATA_W - IDX_W - 2 * COORD_WIDTH_DEF){1'b0}}, y, x, slot};
    do @(posedge clk); while (!in_tready);
    if (op == OP_LOAD) loaded_slots[slot] = 1'b1;
    items_sent++;
  endtask

  // drop valid and wait for the pipe to run dry
  task automatic settle_pipe();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // point count is only changed with nothing in flight
  task automatic write_points(input logic [CFG_W-1:0] value);
    settle_pipe();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    points_setting = value;
  endtask

  // fill the slots a query would walk first, then mix queries and reloads
  task automatic random_item();
    int n;
    int gap_slot;
    n = (points_setting > MAX_POINTS_DEF) ? MAX_POINTS_DEF : points_setting;
    gap_slot = -1;
    for (int k = n - 1; k >= 0; k--) begin
      if (!loaded_slots[k]) gap_slot = k;
    end
    if (gap_slot < 0 && $urandom_range(99) < 40) begin
      send_item(OP_QUERY, IDX_W'($urandom), pick_coord(), pick_coord());
    end else if (gap_slot >= 0 && $urandom_range(3) != 0) begin
      send_item(OP_LOAD, IDX_W'(gap_slot), pick_coord(), pick_coord());
    end else begin
      send_item(OP_LOAD, IDX_W'($urandom_range(MAX_POINTS_DEF - 1)), pick_coord(), pick_coord());
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tuser       = OP_LOAD;
    in_tdata       = '0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    in_gap_pct     = 26;
    out_gap_pct    = 86;
    loaded_slots   = '0;
    points_setting = CFG_RESET;
    items_sent     = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: single point, coordinate extremes
    write_points(6'd1);
    send_item(OP_LOAD, 5'd0, 16'sh8000, 16'sh8000);
    // widest spread on both axes, the largest distance there is
    send_item(OP_QUERY, 5'd0, 16'sh7fff, 16'sh7fff);
    // probe on top of the point
    send_item(OP_QUERY, 5'd0, 16'sh8000, 16'sh8000);
    send_item(OP_LOAD, 5'd0, 16'sh7fff, 16'sh8000);
    // index field is a don't-care on a query
    send_item(OP_QUERY, 5'd31, 16'sh8000, 16'sh7fff);
    send_item(OP_QUERY, 5'd0, 16'sh0000, 16'sh0000);
    send_item(OP_QUERY, 5'd21, 16'sh7fff, 16'sh8000);
    send_item(OP_LOAD, 5'd31, 16'sh5555, -16'sh5556);
    send_item(OP_LOAD, 5'd1, 16'sd3, 16'sd4);

    // two points per column, exact 3-4-5 case
    write_points(6'd2);
    send_item(OP_QUERY, 5'd0, 16'sh0000, 16'sh0000);
    send_item(OP_QUERY, 5'd10, -16'sh5556, 16'sh5555);
    send_item(OP_QUERY, 5'd0, 16'sd3, 16'sd4);

    // zero count: queries produce nothing, loads still land
    write_points(6'd0);
    send_item(OP_QUERY, 5'd0, -16'sd1, -16'sd1);
    send_item(OP_LOAD, 5'd2, 16'sh0001, -16'sd1);
    send_item(OP_QUERY, 5'd31, 16'sh7fff, 16'sh7fff);

    // random phases; idling pattern moves with the item count
    foreach (phase_setting[p]) begin
      write_points(phase_setting[p]);
      repeat (PHASE_ITEMS) begin
        if (items_sent >= 282) begin
          in_gap_pct  = 0;
          out_gap_pct = 0;
        end else if (items_sent >= 141) begin
          in_gap_pct  = 86;
          out_gap_pct = 26;
        end
        random_item();
      end
    end

    settle_pipe();
    if (fail_count == 0) begin
      $display("tb_pairwise_distance_engine OK");
    end else begin
      $display("tb_pairwise_distance_engine NOT OK");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/pdist_pkg.sv
hdl/pdist_point_mem.sv
hdl/pdist_dist_front.sv
hdl/pdist_sqrt_cell.sv
hdl/pairwise_distance_engine.sv
bench/pdist_column_check.sv
bench/tb_pairwise_distance_engine.sv
